### sv/i2d_pkg.sv
// -----------------------------------------------------------------------------
// i2d_pkg
// shared types and constants of the integer to decimal ascii converter
// -----------------------------------------------------------------------------
package i2d_pkg;

   localparam logic       CMD_SIGNED      = 1'b0;
   localparam logic       CMD_UNSIGNED    = 1'b1;

   localparam logic [7:0] CHAR_ZERO       = 8'd48;
   localparam logic [7:0] CHAR_MINUS      = 8'd45;

   localparam int         BITS_PER_STEP   = 4;
   localparam int         QUEUE_DEPTH     = 2;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CONV = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   typedef enum logic [1:0] {
      B_IDLE = 2'b01,
      B_EMIT = 2'b10
   } back_state_type;

endpackage

### sv/i2d_front.sv
// -----------------------------------------------------------------------------
// i2d_front
// accepts a number, forms sign and magnitude, converts it to bcd by
// shift-and-add-3 four bits per cycle and hands the digits to the queue
// -----------------------------------------------------------------------------
module i2d_front #(
   parameter int VALUE_WIDTH = 32,
   parameter int DIGITS      = 10,
   parameter int COUNT_WIDTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_command,
   input  logic [VALUE_WIDTH-1:0]            req_value,
   input  i2d_pkg::queue_status_type         queue_status,
   output logic                              push,
   output logic                              push_negative,
   output logic [COUNT_WIDTH-1:0]            push_count,
   output logic [DIGITS*4-1:0]               push_digits
);
   import i2d_pkg::*;

   localparam int STEPS      = (VALUE_WIDTH + BITS_PER_STEP - 1) / BITS_PER_STEP;
   localparam int PAD_WIDTH  = STEPS * BITS_PER_STEP;
   localparam int STEP_WIDTH = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int BCD_WIDTH  = DIGITS * 4;

   front_state_type         state_ff, state_in;
   logic [PAD_WIDTH-1:0]    mag_ff, mag_in;
   logic [BCD_WIDTH-1:0]    bcd_ff, bcd_in;
   logic                    neg_ff, neg_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;

   logic                    accept;
   logic                    value_neg;
   logic [VALUE_WIDTH-1:0]  value_mag;
   logic [BCD_WIDTH-1:0]    bcd_step;
   logic [PAD_WIDTH-1:0]    mag_step;
   logic [COUNT_WIDTH-1:0]  digit_count;

   assign req_stall = (state_ff != F_IDLE);
   assign accept    = req_valid && !req_stall;
   assign value_neg = (req_command == CMD_SIGNED) && req_value[VALUE_WIDTH-1];
   assign value_mag = value_neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;

   // four double-dabble bit steps
   always_comb begin
      bcd_step = bcd_ff;
      mag_step = mag_ff;
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_step[d*4 +: 4] >= 4'd5) begin
               bcd_step[d*4 +: 4] = bcd_step[d*4 +: 4] + 4'd3;
            end
         end
         bcd_step = {bcd_step[BCD_WIDTH-2:0], mag_step[PAD_WIDTH-1]};
         mag_step = {mag_step[PAD_WIDTH-2:0], 1'b0};
      end
   end

   // number of significant digits, at least one
   always_comb begin
      digit_count = COUNT_WIDTH'(1);
      for (int d = 1; d < DIGITS; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            digit_count = COUNT_WIDTH'(d + 1);
         end
      end
   end

   assign push          = (state_ff == F_PUSH) && !queue_status.full;
   assign push_negative = neg_ff;
   assign push_count    = digit_count;
   assign push_digits   = bcd_ff;

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               mag_in   = PAD_WIDTH'(value_mag);
               neg_in   = value_neg;
               bcd_in   = '0;
               step_in  = '0;
               state_in = F_CONV;
            end
         end
         F_CONV: begin
            mag_in  = mag_step;
            bcd_in  = bcd_step;
            step_in = step_ff + STEP_WIDTH'(1);
            if (step_ff == STEP_WIDTH'(STEPS - 1)) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!queue_status.full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      step_ff <= step_in;
   end

endmodule

### sv/i2d_queue.sv
// -----------------------------------------------------------------------------
// i2d_queue
// two-entry queue of converted numbers between front and back
// -----------------------------------------------------------------------------
module i2d_queue #(
   parameter int WIDTH = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output i2d_pkg::queue_status_type   status
);
   import i2d_pkg::*;

   localparam int PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]       entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   fill_ff, fill_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (fill_ff == CNT_WIDTH'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                              : wr_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0
                                                              : rd_ptr_ff + PTR_WIDTH'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CNT_WIDTH'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### sv/i2d_back.sv
// -----------------------------------------------------------------------------
// i2d_back
// takes converted numbers from the queue and sends their characters,
// sign first, most significant digit first, one transfer per cycle while rsp_stall is low
// -----------------------------------------------------------------------------
module i2d_back #(
   parameter int DIGITS      = 10,
   parameter int COUNT_WIDTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  i2d_pkg::queue_status_type   queue_status,
   output logic                        pop,
   input  logic                        pop_negative,
   input  logic [COUNT_WIDTH-1:0]      pop_count,
   input  logic [DIGITS*4-1:0]         pop_digits,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);
   import i2d_pkg::*;

   localparam int IDX_WIDTH = $clog2(DIGITS);

   back_state_type            state_ff, state_in;
   logic [DIGITS*4-1:0]       digits_ff, digits_in;
   logic                      neg_ff, neg_in;
   logic [IDX_WIDTH-1:0]      idx_ff, idx_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_character_ff, rsp_character_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      out_free;
   logic [3:0]                cur_digit;

   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign cur_digit     = digits_ff[idx_ff*4 +: 4];
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last      = rsp_last_ff;

   always_comb begin
      state_in         = state_ff;
      digits_in        = digits_ff;
      neg_in           = neg_ff;
      idx_in           = idx_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_character_in = rsp_character_ff;
      rsp_last_in      = rsp_last_ff;
      pop              = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!queue_status.empty) begin
               pop       = 1'b1;
               digits_in = pop_digits;
               neg_in    = pop_negative;
               idx_in    = IDX_WIDTH'(pop_count - COUNT_WIDTH'(1));
               state_in  = B_EMIT;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (neg_ff) begin
                  rsp_character_in = CHAR_MINUS;
                  rsp_last_in      = 1'b0;
                  neg_in           = 1'b0;
               end else begin
                  rsp_character_in = CHAR_ZERO + {4'd0, cur_digit};
                  rsp_last_in      = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = B_IDLE;
                  end else begin
                     idx_in = idx_ff - IDX_WIDTH'(1);
                  end
               end
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      digits_ff        <= digits_in;
      neg_ff           <= neg_in;
      idx_ff           <= idx_in;
      rsp_character_ff <= rsp_character_in;
      rsp_last_ff      <= rsp_last_in;
   end

endmodule

### sv/integer_to_decimal_ascii.sv
// -----------------------------------------------------------------------------
// integer_to_decimal_ascii
// converts a signed or unsigned integer to its decimal ascii text
// -----------------------------------------------------------------------------
// a number passes the front states F_CONV and F_PUSH, the queue and the back
//   state B_EMIT, which sends its characters from registers
// the front can convert the next number while the back still sends the last,
//   one character per cycle while rsp_stall is low
// reset: synchronous; clears both state machines, the queue and rsp_valid
module integer_to_decimal_ascii #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_command,
   input  logic [VALUE_WIDTH-1:0]  req_value,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [7:0]              rsp_character,
   output logic                    rsp_last
);
   import i2d_pkg::*;

   localparam int DIGITS      = ((VALUE_WIDTH * 1233) >> 12) + 1;
   localparam int COUNT_WIDTH = $clog2(DIGITS + 1);
   localparam int ENTRY_WIDTH = 1 + COUNT_WIDTH + DIGITS * 4;

   queue_status_type          queue_status;
   logic                      push;
   logic                      push_negative;
   logic [COUNT_WIDTH-1:0]    push_count;
   logic [DIGITS*4-1:0]       push_digits;
   logic                      pop;
   logic [ENTRY_WIDTH-1:0]    pop_data;

   i2d_front #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_value     (req_value),
      .queue_status  (queue_status),
      .push          (push),
      .push_negative (push_negative),
      .push_count    (push_count),
      .push_digits   (push_digits)
   );

   i2d_queue #(
      .WIDTH (ENTRY_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_negative, push_count, push_digits}),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   i2d_back #(
      .DIGITS      (DIGITS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop           (pop),
      .pop_negative  (pop_data[ENTRY_WIDTH-1]),
      .pop_count     (pop_data[DIGITS*4 +: COUNT_WIDTH]),
      .pop_digits    (pop_data[DIGITS*4-1:0]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### sv/i2d_checker.sv
// -----------------------------------------------------------------------------
// i2d_checker
// port-level checks of the integer to decimal ascii converter
// -----------------------------------------------------------------------------
module i2d_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_character,
   input logic        rsp_last
);
   import i2d_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("stalled result changed");

   // only sign or digit characters
   a_rsp_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS) ||
                    ((rsp_character >= CHAR_ZERO) && (rsp_character <= 8'd57)))
      else $error("bad character");

   // a sign is always followed by digits
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("sign marked last");

   // no result right after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind integer_to_decimal_ascii i2d_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last)
);
